FILE: hw/rtl/qte_pkg.sv
// Shared types, widths and the arctangent table for the quaternion to Euler
// angle pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  // datapath width of the cordic x/y registers
  localparam int XW = 38;
  // width of the Q.24 angle accumulator
  localparam int ZW = 27;
  // entries in the arctangent table
  localparam int ATAN_LEN = 24;
  // pi/2 in Q.24
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 27'sd26353589;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;

  // rotation matrix terms that travel beside the square root
  typedef struct packed {
    logic signed [33:0] r11;
    logic signed [33:0] r12;
    logic signed [33:0] r31;
    logic signed [33:0] r32;
    logic signed [31:0] r21;
    logic               clamped;
  } qte_terms_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0: v = 27'sd13176795;
      5'd1: v = 27'sd7778716;
      5'd2: v = 27'sd4110060;
      5'd3: v = 27'sd2086331;
      5'd4: v = 27'sd1047214;
      5'd5: v = 27'sd524117;
      5'd6: v = 27'sd262123;
      5'd7: v = 27'sd131069;
      5'd8: v = 27'sd65536;
      5'd9: v = 27'sd32768;
      5'd10: v = 27'sd16384;
      5'd11: v = 27'sd8192;
      5'd12: v = 27'sd4096;
      5'd13: v = 27'sd2048;
      5'd14: v = 27'sd1024;
      5'd15: v = 27'sd512;
      5'd16: v = 27'sd256;
      5'd17: v = 27'sd128;
      5'd18: v = 27'sd64;
      5'd19: v = 27'sd32;
      5'd20: v = 27'sd16;
      5'd21: v = 27'sd8;
      5'd22: v = 27'sd4;
      5'd23: v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/qte_terms.sv
// Rotation matrix terms from the quaternion: products, sums, arcsine clamp
// and the squared magnitude of the pitch term. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_terms import qte_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    out_valid,
  output qte_terms_t              out_terms,
  output logic [60:0]             out_t2
);

  logic signed [31:0] ww, xx, yy, zz, xy, wz, wy, xz, yz, wx;
  logic               v1, v2;
  qte_terms_t         terms2;
  logic [30:0]        mag2;
  logic signed [33:0] r21_full;
  qte_terms_t         terms_next;
  logic [30:0]        mag_next;
  logic [61:0]        sq;

  // stage 1: component products
  always_ff @(posedge clk) begin
    ww <= quat_w * quat_w;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    xy <= quat_x * quat_y;
    wz <= quat_w * quat_z;
    wy <= quat_w * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    wx <= quat_w * quat_x;
  end

  // stage 2 logic: sums and clamp of the arcsine argument
  always_comb begin
    terms_next.r11 = (34'(xy) + 34'(wz)) <<< 1;
    terms_next.r12 = 34'(ww) + 34'(xx) - 34'(yy) - 34'(zz);
    terms_next.r31 = (34'(yz) + 34'(wx)) <<< 1;
    terms_next.r32 = 34'(ww) - 34'(xx) - 34'(yy) + 34'(zz);
    r21_full = (34'(wy) - 34'(xz)) <<< 1;
    terms_next.clamped = 1'b0;
    if (r21_full > 34'sd1073741824) begin
      terms_next.r21 = 32'sd1073741824;
      terms_next.clamped = 1'b1;
    end else if (r21_full < -34'sd1073741824) begin
      terms_next.r21 = -32'sd1073741824;
      terms_next.clamped = 1'b1;
    end else begin
      terms_next.r21 = 32'(r21_full);
    end
    mag_next = terms_next.r21[31] ? 31'(-terms_next.r21) : 31'(terms_next.r21);
  end

  always_ff @(posedge clk) begin
    terms2 <= terms_next;
    mag2 <= mag_next;
  end

  // stage 3: square of the clamped term
  assign sq = 62'(mag2) * 62'(mag2);

  always_ff @(posedge clk) begin
    out_terms <= terms2;
    out_t2 <= sq[60:0];
  end

  // valid travels with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/qte_sqrt.sv
// Pipelined integer square root of (2^60 - t2), one result bit per stage,
// carrying the matrix terms alongside. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt import qte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire qte_terms_t  in_terms,
  input  wire logic [60:0] in_t2,
  output logic             out_valid,
  output qte_terms_t       out_terms,
  output logic [30:0]      out_root
);

  localparam int NB = 31;

  logic [61:0] rem  [0:NB];
  logic [30:0] root [0:NB];
  qte_terms_t  side [0:NB];
  logic        vld  [0:NB];

  // radicand stage
  always_ff @(posedge clk) begin
    rem[0] <= (62'd1 << 60) - 62'(in_t2);
    root[0] <= '0;
    side[0] <= in_terms;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
  end

  // one root bit per stage, most significant first
  for (genvar k = 1; k <= NB; k++) begin : g_bit
    localparam int I = NB - k;
    logic [61:0] cand;
    assign cand = (62'(root[k-1]) << (I + 1)) + (62'd1 << (2 * I));

    always_ff @(posedge clk) begin
      if (rem[k-1] >= cand) begin
        rem[k] <= rem[k-1] - cand;
        root[k] <= root[k-1] | (31'd1 << I);
      end else begin
        rem[k] <= rem[k-1];
        root[k] <= root[k-1];
      end
      side[k] <= side[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else vld[k] <= vld[k-1];
    end
  end

  assign out_valid = vld[NB];
  assign out_terms = side[NB];
  assign out_root = root[NB];

endmodule
`default_nettype wire

FILE: hw/rtl/qte_cordic.sv
// Pipelined vectoring cordic atan2 with half plane turn, rounding to Q3.13
// and saturation. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic import qte_pkg::*; #(
  parameter int ITERS = 16,
  parameter int OUT_W = 16,
  parameter int LIMIT = 25736
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic signed [XW-1:0]    in_y,
  input  wire logic signed [XW-1:0]    in_x,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_angle
);

  localparam int N = (ITERS < ATAN_LEN) ? ITERS : ATAN_LEN;
  localparam logic signed [15:0] LIM = 16'(LIMIT);

  logic signed [XW-1:0] xs [0:N];
  logic signed [XW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic                 zf [0:N];
  logic                 vld [0:N];
  logic signed [ZW-1:0] zr;
  logic signed [15:0]   rnd;
  logic signed [15:0]   sat;

  // half plane turn and zero vector detect
  always_ff @(posedge clk) begin
    zf[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        xs[0] <= in_y;
        ys[0] <= -in_x;
        zs[0] <= HALF_PI_Q24;
      end else begin
        xs[0] <= -in_y;
        ys[0] <= in_x;
        zs[0] <= -HALF_PI_Q24;
      end
    end else begin
      xs[0] <= in_x;
      ys[0] <= in_y;
      zs[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
  end

  // micro-rotations, one per stage
  for (genvar k = 0; k < N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (ys[k] >= 0) begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + atan_q24(5'(k));
      end else begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - atan_q24(5'(k));
      end
      zf[k+1] <= zf[k];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
    end
  end

  // round Q.24 to Q3.13 and saturate
  always_comb begin
    zr = zs[N] + ZW'(1024);
    rnd = 16'(zr >>> 11);
    if (zf[N]) sat = '0;
    else if (rnd > LIM) sat = LIM;
    else if (rnd < -LIM) sat = -LIM;
    else sat = rnd;
  end

  always_ff @(posedge clk) begin
    out_angle <= OUT_W'(sat);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[N];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles.sv
// Top level: ZYX Euler angles from a Q1.15 quaternion.
// Depends on qte_pkg, qte_terms, qte_sqrt and qte_cordic.
//
// A quaternion word is taken whenever start is high; busy is always low, so
// one word per clock is accepted. Each word yields one result word, shown
// for a single cycle with done high, once it has passed the products and
// matrix terms, the radicand and bit-per-stage square root that feeds the
// arcsine, the half plane turn, the cordic iterations and rounding. The
// receiver cannot stall, so results must be captured on the cycle done is
// high.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    done,
  output logic signed [15:0]      yaw_angle,
  output logic signed [14:0]      pitch_angle,
  output logic signed [15:0]      roll_angle,
  output logic                    pitch_clamped
);

  localparam int N = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
  localparam int CD = N + 2;

  logic        t_valid, s_valid;
  qte_terms_t  t_terms, s_terms;
  logic [60:0] t_t2;
  logic [30:0] s_root;
  logic        v_yaw, v_pitch, v_roll;
  logic        clamp_d [0:CD-1];

  assign busy = 1'b0;

  qte_terms u_terms (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(t_valid), .out_terms(t_terms), .out_t2(t_t2)
  );

  qte_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(t_valid), .in_terms(t_terms), .in_t2(t_t2),
    .out_valid(s_valid), .out_terms(s_terms), .out_root(s_root)
  );

  // three angle units in lockstep
  qte_cordic #(.ITERS(CORDIC_ITERATIONS), .OUT_W(16), .LIMIT(PI_Q13)) u_yaw (
    .clk(clk), .rst(rst), .in_valid(s_valid),
    .in_y(XW'(s_terms.r11)), .in_x(XW'(s_terms.r12)),
    .out_valid(v_yaw), .out_angle(yaw_angle)
  );

  qte_cordic #(.ITERS(CORDIC_ITERATIONS), .OUT_W(15), .LIMIT(HALF_PI_Q13)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(s_valid),
    .in_y(XW'(s_terms.r21)), .in_x(signed'(XW'(s_root))),
    .out_valid(v_pitch), .out_angle(pitch_angle)
  );

  qte_cordic #(.ITERS(CORDIC_ITERATIONS), .OUT_W(16), .LIMIT(PI_Q13)) u_roll (
    .clk(clk), .rst(rst), .in_valid(s_valid),
    .in_y(XW'(s_terms.r31)), .in_x(XW'(s_terms.r32)),
    .out_valid(v_roll), .out_angle(roll_angle)
  );

  // clamp flag delay matching the cordic latency
  always_ff @(posedge clk) begin
    clamp_d[0] <= s_terms.clamped;
    for (int i = 1; i < CD; i++) clamp_d[i] <= clamp_d[i-1];
  end

  assign pitch_clamped = clamp_d[CD-1];
  assign done = v_yaw && v_pitch && v_roll;

endmodule
`default_nettype wire

FILE: hw/rtl/qte_checker.sv
// Port-level checks for the quaternion to Euler angle block, bound to the
// top level. Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module qte_checker #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic signed [15:0] quat_w,
  input wire logic signed [15:0] quat_x,
  input wire logic signed [15:0] quat_y,
  input wire logic signed [15:0] quat_z,
  input wire logic               done,
  input wire logic signed [15:0] yaw_angle,
  input wire logic signed [14:0] pitch_angle,
  input wire logic signed [15:0] roll_angle,
  input wire logic               pitch_clamped
);

  localparam int LAT = ((CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24) + 37;

  // always ready for a word
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every result word traces back to an accepted word
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an accepted word");

  // angles stay within their ranges
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736))
    else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles qte_checker #(
  .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
) u_qte_checker (.*);
`default_nettype wire
